@@ sv/lfe_bq_pkg.sv @@
// ----------------------------------------------------------------------------
// LFE biquad package
// Shared widths, constants, register indexes and sequencer codes for the
// LFE downmix / biquad low-pass unit.
// ----------------------------------------------------------------------------
package lfe_bq_pkg;

   // Default parameter values
   localparam int BED_COUNT_DEF      = 7;
   localparam int COEF_FRAC_BITS_DEF = 28;

   // Fixed field widths
   localparam int NUM_BEDS = 7;   // bed sample ports
   localparam int IDX_W    = 3;   // bed slot index
   localparam int IN_W     = 24;  // PCM sample
   localparam int COEF_W   = 32;  // Q4.28 coefficient
   localparam int MASK_W   = 7;
   localparam int RECIP_W  = 17;  // Q1.16 reciprocal
   localparam int CSR_IDX_W = 3;

   // Shared multiplier and accumulator
   localparam int OP_A_W = 28;                 // signed data operand
   localparam int PROD_W = OP_A_W + COEF_W;    // one partial product
   localparam int ACC_W  = 81;                 // holds a 48 x 32 product plus rounding

   // Filter values: 48 bits, 39 fraction bits
   localparam int STATE_W    = 48;
   localparam int STATE_FRAC = 39;
   localparam int HALF_W     = 24;             // split of a wide operand
   localparam int G_W        = 41;             // gain stage output, +/- 2^39
   localparam int GF_W       = 48;             // gain product before the clamp
   localparam int SF_W       = 26;             // scaled sample before the clamp
   localparam int MONO_F_W   = 28;             // mono before the clamp

   // Fixed gains
   localparam logic signed [COEF_W-1:0] GAIN_Q24   = 32'sd5305422;  // -10 dB, Q8.24
   localparam logic signed [COEF_W-1:0] FULL_SCALE = 32'sd8388607;

   // Register reset values
   localparam logic signed [COEF_W-1:0] B0_RST   = 32'sd16377;
   localparam logic signed [COEF_W-1:0] B1_RST   = 32'sd32753;
   localparam logic signed [COEF_W-1:0] A1_RST   = -32'sd530908960;
   localparam logic signed [COEF_W-1:0] A2_RST   = 32'sd262537929;
   localparam logic [MASK_W-1:0]        MASK_RST = 7'h7F;
   localparam logic [RECIP_W-1:0]       RECIP_RST = 17'd9362;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_B0     = 3'd0,
      CSR_COEF_B1     = 3'd1,
      CSR_COEF_A1     = 3'd2,
      CSR_COEF_A2     = 3'd3,
      CSR_BED_MASK    = 3'd4,
      CSR_RECIP_BEDS  = 3'd5,
      CSR_DEPTH_16BIT = 3'd6
   } csr_index_type;

   // Shift applied to a partial product before accumulation
   typedef enum logic [1:0] {
      SH_NONE = 2'd0,
      SH_16   = 2'd1,
      SH_24   = 2'd2
   } shift_sel_type;

   // Sequencer states, one-hot
   typedef enum logic [16:0] {
      ST_IDLE    = 17'h00001,
      ST_SUM     = 17'h00002,
      ST_MONO    = 17'h00004,
      ST_MONO_WB = 17'h00008,
      ST_XB0     = 17'h00010,
      ST_XB1     = 17'h00020,
      ST_Y       = 17'h00040,
      ST_YA1_LO  = 17'h00080,
      ST_YA1_HI  = 17'h00100,
      ST_YA2_LO  = 17'h00200,
      ST_YA2_HI  = 17'h00400,
      ST_YG_LO   = 17'h00800,
      ST_YG_HI   = 17'h01000,
      ST_G_WB    = 17'h02000,
      ST_GS_LO   = 17'h04000,
      ST_GS_HI   = 17'h08000,
      ST_OUT     = 17'h10000
   } state_type;

endpackage

@@ sv/lfe_synth_biquad_lowpass_unit.sv @@
// ----------------------------------------------------------------------------
// LFE synthesis unit
// Masked bed downmix, transposed direct form II biquad low-pass and -10 dB
// gain, producing one saturated LFE sample per frame. All multiplies run on
// one shared 28 x 32 multiplier-accumulator under a one-hot sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  req      in   req_valid/stall    seven 24-bit bed samples per beat
//  rsp      out  rsp_valid/stall    rsp_lfe_sample, 24-bit signed
//  csr      in   csr_wr_en          csr_index, csr_wdata (32-bit)
//
//  Each beat is worked from acceptance to the next accept in one MAC pass per
//  bed slot, masked or not, then MAC passes and write-back states for the
//  mono scaling, filter and gain on the single shared multiplier.
//  req_stall is high whenever the sequencer is busy. A finished sample sits
//  in the output register; the next frame is taken while it waits, and only
//  the final write-back waits for the register to drain.
//  Synchronous reset clears configuration to defaults and both delay lines.
//
module lfe_synth_biquad_lowpass_unit
   import lfe_bq_pkg::*;
#(
   parameter int BED_COUNT      = BED_COUNT_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [IN_W-1:0]   req_front_left,
   input  logic signed [IN_W-1:0]   req_front_right,
   input  logic signed [IN_W-1:0]   req_center,
   input  logic signed [IN_W-1:0]   req_left_surround,
   input  logic signed [IN_W-1:0]   req_right_surround,
   input  logic signed [IN_W-1:0]   req_left_back,
   input  logic signed [IN_W-1:0]   req_right_back,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [IN_W-1:0]   rsp_lfe_sample,

   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_wdata
);

   // Widths that follow from the coefficient fraction
   localparam int XB_W = 72 - COEF_FRAC_BITS;            // x * b product
   localparam int YA_W = 81 - COEF_FRAC_BITS;            // y * a product
   localparam int NZ_W = YA_W + 2;                       // delay update sum
   localparam int YS_W = ((XB_W > STATE_W) ? XB_W : STATE_W) + 1;
   localparam logic signed [ACC_W-1:0] RND_F  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] RND_15 = ACC_W'(1) <<< 15;
   localparam logic signed [ACC_W-1:0] RND_23 = ACC_W'(1) <<< 23;
   localparam logic signed [ACC_W-1:0] RND_38 = ACC_W'(1) <<< (STATE_FRAC - 1);
   localparam logic signed [GF_W-1:0]  G_MAX  = GF_W'(1) <<< STATE_FRAC;
   localparam logic signed [GF_W-1:0]  G_MIN  = -G_MAX;

   // Configuration registers
   logic signed [COEF_W-1:0]  coef_b0_ff, coef_b1_ff, coef_a1_ff, coef_a2_ff;
   logic [MASK_W-1:0]         bed_mask_ff;
   logic [RECIP_W-1:0]        recip_beds_ff;
   logic                      depth_16bit_ff;

   // Sequencer and datapath
   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          cnt_ff, cnt_in;
   logic signed [IN_W-1:0]    smp_ff [NUM_BEDS];
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [IN_W-1:0]    mono_ff, mono_in;
   logic signed [XB_W-1:0]    xb0_ff, xb1_ff;
   logic signed [STATE_W-1:0] y_ff, y_in;
   logic signed [STATE_W-1:0] delay_one_ff, delay_one_in;
   logic signed [STATE_W-1:0] delay_two_ff, delay_two_in;
   logic signed [G_W-1:0]     g_ff, g_in;
   logic                      rsp_valid_ff;
   logic signed [IN_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      out_load;

   // Shared multiplier-accumulator controls
   logic signed [OP_A_W-1:0]  op_a;
   logic signed [COEF_W-1:0]  op_c;
   shift_sel_type             sh_sel;
   logic                      acc_keep;     // add onto acc instead of a fresh base
   logic signed [ACC_W-1:0]   acc_base;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   prod_sh;

   // Operand views
   logic signed [IN_W-1:0]    smp_cur;
   logic signed [IN_W-1:0]    smp_val;
   logic signed [HALF_W-1:0]  y_hi;
   logic signed [G_W-HALF_W-1:0] g_hi;

   // Accumulator read-outs
   logic signed [ACC_W-1:0]   acc_sh_f, acc_sh16, acc_sh24, acc_sh39;
   logic signed [XB_W-1:0]    xb_res;
   logic signed [YA_W-1:0]    ya_res;
   logic signed [MONO_F_W-1:0] mono_full;
   logic signed [GF_W-1:0]    g_full;
   logic signed [SF_W-1:0]    s_full;

   // Saturation intermediates
   logic signed [YS_W-1:0]    y_sum;
   logic signed [NZ_W-1:0]    nz1, nz2;
   logic signed [IN_W-1:0]    s24;
   logic signed [IN_W:0]      s_rnd;
   logic signed [IN_W-8:0]    s_q;
   logic signed [15:0]        s16;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_lfe_sample = rsp_data_ff;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Current bed sample; 16-bit mode reads the low half and shifts it up by 8 bits
   assign smp_cur = smp_ff[cnt_ff];
   assign smp_val = depth_16bit_ff ? {smp_cur[15:0], 8'h00} : smp_cur;
   assign y_hi    = y_ff[STATE_W-1:HALF_W];
   assign g_hi    = g_ff[G_W-1:HALF_W];

   // Sequencer: operand selection and next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_a     = '0;
      op_c     = '0;
      sh_sel   = SH_NONE;
      acc_keep = 1'b1;
      acc_base = '0;
      unique case (state_ff)
         ST_IDLE: begin
            acc_keep = 1'b0;
            cnt_in   = '0;
            if (accept) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            op_a   = OP_A_W'(smp_val);
            op_c   = COEF_W'({1'b0, bed_mask_ff[cnt_ff]});
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(BED_COUNT - 1)) begin
               state_in = ST_MONO;
            end
         end
         ST_MONO: begin
            op_a     = acc_ff[OP_A_W-1:0];
            op_c     = COEF_W'(recip_beds_ff);
            acc_keep = 1'b0;
            acc_base = RND_15;
            state_in = ST_MONO_WB;
         end
         ST_MONO_WB: begin
            state_in = ST_XB0;
         end
         ST_XB0: begin
            op_a     = OP_A_W'(mono_ff);
            op_c     = coef_b0_ff;
            sh_sel   = SH_16;
            acc_keep = 1'b0;
            acc_base = RND_F;
            state_in = ST_XB1;
         end
         ST_XB1: begin
            op_a     = OP_A_W'(mono_ff);
            op_c     = coef_b1_ff;
            sh_sel   = SH_16;
            acc_keep = 1'b0;
            acc_base = RND_F;
            state_in = ST_Y;
         end
         ST_Y: begin
            state_in = ST_YA1_LO;
         end
         ST_YA1_LO: begin
            op_a     = OP_A_W'({1'b0, y_ff[HALF_W-1:0]});
            op_c     = coef_a1_ff;
            acc_keep = 1'b0;
            acc_base = RND_F;
            state_in = ST_YA1_HI;
         end
         ST_YA1_HI: begin
            op_a     = OP_A_W'(y_hi);
            op_c     = coef_a1_ff;
            sh_sel   = SH_24;
            state_in = ST_YA2_LO;
         end
         ST_YA2_LO: begin
            op_a     = OP_A_W'({1'b0, y_ff[HALF_W-1:0]});
            op_c     = coef_a2_ff;
            acc_keep = 1'b0;
            acc_base = RND_F;
            state_in = ST_YA2_HI;
         end
         ST_YA2_HI: begin
            op_a     = OP_A_W'(y_hi);
            op_c     = coef_a2_ff;
            sh_sel   = SH_24;
            state_in = ST_YG_LO;
         end
         ST_YG_LO: begin
            op_a     = OP_A_W'({1'b0, y_ff[HALF_W-1:0]});
            op_c     = GAIN_Q24;
            acc_keep = 1'b0;
            acc_base = RND_23;
            state_in = ST_YG_HI;
         end
         ST_YG_HI: begin
            op_a     = OP_A_W'(y_hi);
            op_c     = GAIN_Q24;
            sh_sel   = SH_24;
            state_in = ST_G_WB;
         end
         ST_G_WB: begin
            state_in = ST_GS_LO;
         end
         ST_GS_LO: begin
            op_a     = OP_A_W'({1'b0, g_ff[HALF_W-1:0]});
            op_c     = FULL_SCALE;
            acc_keep = 1'b0;
            acc_base = RND_38;
            state_in = ST_GS_HI;
         end
         ST_GS_HI: begin
            op_a     = OP_A_W'(g_hi);
            op_c     = FULL_SCALE;
            sh_sel   = SH_24;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Shared multiply-accumulate
   assign prod     = op_a * op_c;
   assign prod_ext = ACC_W'(prod);
   always_comb begin
      unique case (sh_sel)
         SH_NONE: prod_sh = prod_ext;
         SH_16:   prod_sh = prod_ext <<< 16;
         SH_24:   prod_sh = prod_ext <<< HALF_W;
         default: prod_sh = prod_ext;
      endcase
   end
   assign acc_in = (acc_keep ? acc_ff : acc_base) + prod_sh;

   // Rounded accumulator views
   assign acc_sh_f  = acc_ff >>> COEF_FRAC_BITS;
   assign acc_sh16  = acc_ff >>> 16;
   assign acc_sh24  = acc_ff >>> HALF_W;
   assign acc_sh39  = acc_ff >>> STATE_FRAC;
   assign xb_res    = acc_sh_f[XB_W-1:0];
   assign ya_res    = acc_sh_f[YA_W-1:0];
   assign mono_full = acc_sh16[MONO_F_W-1:0];
   assign g_full    = acc_sh24[GF_W-1:0];
   assign s_full    = acc_sh39[SF_W-1:0];

   // Mono clamp to Q1.23
   always_comb begin
      if ((&mono_full[MONO_F_W-1:IN_W-1]) || !(|mono_full[MONO_F_W-1:IN_W-1])) begin
         mono_in = mono_full[IN_W-1:0];
      end else begin
         mono_in = mono_full[MONO_F_W-1] ? {1'b1, {(IN_W-1){1'b0}}}
                                         : {1'b0, {(IN_W-1){1'b1}}};
      end
   end

   // Filter output y, saturated to 48 bits
   assign y_sum = YS_W'(xb0_ff) + YS_W'(delay_one_ff);
   always_comb begin
      if ((&y_sum[YS_W-1:STATE_W-1]) || !(|y_sum[YS_W-1:STATE_W-1])) begin
         y_in = y_sum[STATE_W-1:0];
      end else begin
         y_in = y_sum[YS_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                              : {1'b0, {(STATE_W-1){1'b1}}};
      end
   end

   // Delay updates, each saturated to 48 bits
   assign nz1 = NZ_W'(xb1_ff) - NZ_W'(ya_res) + NZ_W'(delay_two_ff);
   assign nz2 = NZ_W'(xb0_ff) - NZ_W'(ya_res);
   always_comb begin
      if ((&nz1[NZ_W-1:STATE_W-1]) || !(|nz1[NZ_W-1:STATE_W-1])) begin
         delay_one_in = nz1[STATE_W-1:0];
      end else begin
         delay_one_in = nz1[NZ_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                    : {1'b0, {(STATE_W-1){1'b1}}};
      end
      if ((&nz2[NZ_W-1:STATE_W-1]) || !(|nz2[NZ_W-1:STATE_W-1])) begin
         delay_two_in = nz2[STATE_W-1:0];
      end else begin
         delay_two_in = nz2[NZ_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                    : {1'b0, {(STATE_W-1){1'b1}}};
      end
   end

   // Gain output clamp to +/- 1.0
   always_comb begin
      priority if (g_full > G_MAX) begin
         g_in = G_W'(G_MAX);
      end else if (g_full < G_MIN) begin
         g_in = G_W'(G_MIN);
      end else begin
         g_in = g_full[G_W-1:0];
      end
   end

   // Output sample: 24-bit clamp, then optional 16-bit rounding
   always_comb begin
      if ((&s_full[SF_W-1:IN_W-1]) || !(|s_full[SF_W-1:IN_W-1])) begin
         s24 = s_full[IN_W-1:0];
      end else begin
         s24 = s_full[SF_W-1] ? {1'b1, {(IN_W-1){1'b0}}}
                              : {1'b0, {(IN_W-1){1'b1}}};
      end
      s_rnd = (IN_W+1)'(s24) + (s24[IN_W-1] ? -(IN_W+1)'(128) : (IN_W+1)'(128));
      s_q   = s_rnd[IN_W:8];
      if (s_q[IN_W-8] == s_q[15]) begin
         s16 = s_q[15:0];
      end else begin
         s16 = s_q[IN_W-8] ? 16'sh8000 : 16'sh7FFF;
      end
      rsp_data_in = depth_16bit_ff ? IN_W'(s16) : s24;
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         delay_one_ff   <= '0;
         delay_two_ff   <= '0;
         coef_b0_ff     <= B0_RST;
         coef_b1_ff     <= B1_RST;
         coef_a1_ff     <= A1_RST;
         coef_a2_ff     <= A2_RST;
         bed_mask_ff    <= MASK_RST;
         recip_beds_ff  <= RECIP_RST;
         depth_16bit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_YA2_LO) begin
            delay_one_ff <= delay_one_in;
         end
         if (state_ff == ST_YG_LO) begin
            delay_two_ff <= delay_two_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_COEF_B0:     coef_b0_ff     <= csr_wdata;
               CSR_COEF_B1:     coef_b1_ff     <= csr_wdata;
               CSR_COEF_A1:     coef_a1_ff     <= csr_wdata;
               CSR_COEF_A2:     coef_a2_ff     <= csr_wdata;
               CSR_BED_MASK:    bed_mask_ff    <= csr_wdata[MASK_W-1:0];
               CSR_RECIP_BEDS:  recip_beds_ff  <= csr_wdata[RECIP_W-1:0];
               CSR_DEPTH_16BIT: depth_16bit_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (accept) begin
         smp_ff[0] <= req_front_left;
         smp_ff[1] <= req_front_right;
         smp_ff[2] <= req_center;
         smp_ff[3] <= req_left_surround;
         smp_ff[4] <= req_right_surround;
         smp_ff[5] <= req_left_back;
         smp_ff[6] <= req_right_back;
      end
      if (state_ff == ST_MONO_WB) begin
         mono_ff <= mono_in;
      end
      if (state_ff == ST_XB1) begin
         xb0_ff <= xb_res;
      end
      if (state_ff == ST_Y) begin
         xb1_ff <= xb_res;
         y_ff   <= y_in;
      end
      if (state_ff == ST_G_WB) begin
         g_ff <= g_in;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Checks
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside the output step");

   a_accept_starts_sum: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SUM) && (cnt_ff == '0))
      else $error("accepted frame did not start the bed sum");

   a_sum_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (cnt_ff < IDX_W'(BED_COUNT)))
      else $error("bed counter ran past the slot count");

   a_out_waits_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result beat was overwritten");

endmodule

@@ verif/tb_lfe_synth_biquad_lowpass_unit.sv @@
// ----------------------------------------------------------------------------
// LFE synthesis unit testbench
// Drives bed frames into the downmix / biquad / gain unit and checks each
// LFE sample against a bit-exact predictor kept in step with the CSR writes.
// A table of directed frames and writes runs first. Random settings follow,
// each with a burst of random frames, in most bursts with random gaps on both
// channels; one burst also gets a long output hold-off.
// ----------------------------------------------------------------------------
module tb_lfe_synth_biquad_lowpass_unit;
   import lfe_bq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1930;
   localparam int SETTLE       = 30;    // a little more than one frame of work
   localparam int TAIL_CYCLES  = 60;
   localparam int HOLD_CYCLES  = 200;
   localparam int QUIET_LIMIT  = 2000;
   localparam int MAX_PRINTS   = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;   // decodes to nothing

   localparam longint S48_MAX  = (longint'(1) <<< 47) - 1;
   localparam longint S48_MIN  = -(longint'(1) <<< 47);
   localparam longint UNITY    = longint'(1) <<< STATE_FRAC;
   localparam longint PCM24_MAX = 8388607;
   localparam longint PCM24_MIN = -8388608;
   localparam longint PCM16_MAX = 32767;
   localparam longint PCM16_MIN = -32768;

   // one frame: slot 0 (front left) in the low bits
   typedef logic [NUM_BEDS-1:0][IN_W-1:0] frame_t;

   typedef enum logic {
      STEP_FRAME,
      STEP_WRITE
   } step_kind_t;

   typedef struct packed {
      step_kind_t            kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [COEF_W-1:0]     wdata;
      frame_t                frame;
      logic                  fixed;      // expected sample typed in below
      logic [IN_W-1:0]       fixed_value;
   } plan_row_t;

   // Directed plan: frames and register writes in order
   localparam int PLAN_ROWS = 36;
   plan_row_t plan [PLAN_ROWS] = '{
      // reset settings, silence then full scale
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h000000}}, 1'b1, 24'h000000},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h7FFFFF}}, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h800000}}, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0,
        {24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000,
         24'h7FFFFF}, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h123456}}, 1'b0, 24'h0},
      // zero coefficients flush the delay line in two frames
      '{STEP_WRITE, CSR_COEF_B0, 32'h0, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_COEF_B1, 32'h0, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_COEF_A1, 32'h0, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_COEF_A2, 32'h0, '0, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h000000}}, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h000000}}, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h000000}}, 1'b1, 24'h000000},
      // b0 near 8, front left alone at unity: gain clamps to full scale
      '{STEP_WRITE, CSR_COEF_B0, 32'h7FFFFFFF, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_BED_MASK, 32'hFFFFFF81, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_RECIP_BEDS, 32'hFFFF0000, '0, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {{6{24'h5A5A5A}}, 24'h7FFFFF},
        1'b1, 24'h7FFFFF},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {{6{24'hA5A5A5}}, 24'h800000},
        1'b1, 24'h800001},
      // 16-bit samples: upper byte ignored, output clamps to the 16-bit range
      '{STEP_WRITE, CSR_DEPTH_16BIT, 32'hFFFFFFFF, '0, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {{6{24'h3C3C3C}}, 24'hA57FFF},
        1'b1, 24'h007FFF},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {{6{24'hC3C3C3}}, 24'h5A8000},
        1'b1, 24'hFF8000},
      // empty mask feeds zero
      '{STEP_WRITE, CSR_BED_MASK, 32'h00000000, '0, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h7FFFFF}}, 1'b0, 24'h0},
      // oversized reciprocal saturates the mono value
      '{STEP_WRITE, CSR_BED_MASK, 32'h000000D5, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_RECIP_BEDS, 32'h0001FFFF, '0, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h007FFF}}, 1'b0, 24'h0},
      // unstable extremes drive the delays into saturation
      '{STEP_WRITE, CSR_DEPTH_16BIT, 32'h00000000, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_COEF_A1, 32'h80000000, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_COEF_A2, 32'h7FFFFFFF, '0, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_COEF_B1, 32'h80000000, '0, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h800000}}, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h7FFFFF}}, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h000000}}, 1'b0, 24'h0},
      // zero reciprocal, then a write to the unused index
      '{STEP_WRITE, CSR_RECIP_BEDS, 32'hFFFE0000, '0, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h7FFFFF}}, 1'b0, 24'h0},
      '{STEP_WRITE, CSR_SPARE, 32'hFFFFFFFF, '0, 1'b0, 24'h0},
      '{STEP_FRAME, CSR_COEF_B0, 32'h0, {7{24'h654321}}, 1'b0, 24'h0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   frame_t                 req_frame = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [IN_W-1:0] rsp_lfe_sample;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_COEF_B0;
   logic [COEF_W-1:0]      csr_wdata = '0;

   // mirror of the configuration and filter delays
   logic signed [COEF_W-1:0] set_b0 = B0_RST;
   logic signed [COEF_W-1:0] set_b1 = B1_RST;
   logic signed [COEF_W-1:0] set_a1 = A1_RST;
   logic signed [COEF_W-1:0] set_a2 = A2_RST;
   logic [MASK_W-1:0]        set_mask = MASK_RST;
   logic [RECIP_W-1:0]       set_recip = RECIP_RST;
   logic                     set_depth16 = 1'b0;
   longint                   dly1 = 0;
   longint                   dly2 = 0;

   logic [IN_W-1:0] lfe_expected [$];
   int              err_count = 0;
   int              quiet_cycles = 0;
   bit              idle_on = 1'b1;
   bit              hold_req = 1'b0;
   int              hold_left = 0;
   int              stall_left = 0;

   lfe_synth_biquad_lowpass_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_front_left     (req_frame[0]),
      .req_front_right    (req_frame[1]),
      .req_center         (req_frame[2]),
      .req_left_surround  (req_frame[3]),
      .req_right_surround (req_frame[4]),
      .req_left_back      (req_frame[5]),
      .req_right_back     (req_frame[6]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lfe_sample     (rsp_lfe_sample),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // floor((a * c + 2^(f-1)) / 2^f), exact at 128 bits
   function automatic longint round_mul(input longint a, input longint c,
                                        input int unsigned f);
      logic signed [127:0] p;
      p = a;
      p = p * c + (128'sd1 <<< (f - 1));
      return longint'(p >>> f);
   endfunction

   // Next LFE sample for one frame; advances the delay line
   function automatic logic [IN_W-1:0] synth_lfe(input frame_t fr);
      longint sum, mono, x, y, nz1, nz2, g, s;
      longint b0, b1, a1, a2;
      int i;
      sum = 0;
      for (i = 0; i < BED_COUNT_DEF; i++) begin
         if (set_mask[i]) begin
            if (set_depth16)
               sum += longint'($signed(fr[i][15:0])) * 256;
            else
               sum += longint'($signed(fr[i]));
         end
      end
      mono = clip((sum * longint'(set_recip) + 32768) >>> 16, PCM24_MIN, PCM24_MAX);
      x = mono <<< (STATE_FRAC - 23);
      b0 = set_b0;
      b1 = set_b1;
      a1 = set_a1;
      a2 = set_a2;
      y = clip(round_mul(x, b0, COEF_FRAC_BITS_DEF) + dly1, S48_MIN, S48_MAX);
      nz1 = round_mul(x, b1, COEF_FRAC_BITS_DEF) - round_mul(y, a1, COEF_FRAC_BITS_DEF)
            + dly2;
      nz2 = round_mul(x, b0, COEF_FRAC_BITS_DEF) - round_mul(y, a2, COEF_FRAC_BITS_DEF);
      dly1 = clip(nz1, S48_MIN, S48_MAX);
      dly2 = clip(nz2, S48_MIN, S48_MAX);
      g = clip(round_mul(y, longint'(GAIN_Q24), 24), -UNITY, UNITY);
      s = clip(round_mul(g, longint'(FULL_SCALE), STATE_FRAC), PCM24_MIN, PCM24_MAX);
      if (set_depth16)
         s = clip(((s >= 0) ? s + 128 : s - 128) >>> 8, PCM16_MIN, PCM16_MAX);
      return s[IN_W-1:0];
   endfunction

   function automatic frame_t rand_frame();
      frame_t fr;
      int unsigned style;
      int i;
      style = $urandom_range(0, 9);
      for (i = 0; i < NUM_BEDS; i++) begin
         case (style)
            0: begin
               case ($urandom_range(0, 3))
                  0: fr[i] = 24'h7FFFFF;
                  1: fr[i] = 24'h800000;
                  2: fr[i] = 24'h000000;
                  default: fr[i] = 24'hFFFFFF;
               endcase
            end
            1, 2: fr[i] = 24'($urandom_range(0, 8191)) - 24'd4096;
            default: fr[i] = 24'($urandom);
         endcase
      end
      return fr;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // One frame beat; the expected sample is queued when the beat is taken
   task automatic send_frame(input frame_t fr, input logic fixed,
                             input logic [IN_W-1:0] fixed_value);
      int gap;
      logic [IN_W-1:0] predicted;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_frame <= fr;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = synth_lfe(fr);
      lfe_expected.push_back(fixed ? fixed_value : predicted);
   endtask

   // Stop sending and wait until every sample is back and the sequencer is quiet
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lfe_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_COEF_B0:     set_b0 = data;
         CSR_COEF_B1:     set_b1 = data;
         CSR_COEF_A1:     set_a1 = data;
         CSR_COEF_A2:     set_a2 = data;
         CSR_BED_MASK:    set_mask = data[MASK_W-1:0];
         CSR_RECIP_BEDS:  set_recip = data[RECIP_W-1:0];
         CSR_DEPTH_16BIT: set_depth16 = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [COEF_W-1:0] extreme_coef();
      case ($urandom_range(0, 3))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h00000000;
         default: return 32'hFFFFFFFF;
      endcase
   endfunction

   // New random setting for the next burst, written while the unit is idle
   task automatic pick_setting();
      logic [COEF_W-1:0] b0, b1, a1, a2;
      logic [MASK_W-1:0] m;
      logic [RECIP_W-1:0] rc;
      longint a2v, bound;
      int unsigned n;
      drain_results();
      case ($urandom_range(0, 9))
         0, 1: begin
            b0 = B0_RST;
            b1 = B1_RST;
            a1 = A1_RST;
            a2 = A2_RST;
         end
         7: begin
            b0 = $urandom;
            b1 = $urandom;
            a1 = $urandom;
            a2 = $urandom;
         end
         8: begin
            b0 = extreme_coef();
            b1 = extreme_coef();
            a1 = extreme_coef();
            a2 = extreme_coef();
         end
         9: begin
            // b0 = b2 = 1.0: y is x plus x two frames back
            b0 = 32'h10000000;
            b1 = '0;
            a1 = '0;
            a2 = '0;
         end
         default: begin
            // inside the stability triangle, |a2| < 0.95 and |a1| < 1 + a2
            a2v = longint'($urandom_range(0, 510027366)) - 255013683;
            bound = ((268435456 + a2v) * 98) / 100;
            a1 = 32'(longint'($urandom_range(0, 32'(2 * bound))) - bound);
            a2 = 32'(a2v);
            b0 = 32'(int'($urandom_range(0, 134217728)) - 67108864);
            b1 = 32'(int'($urandom_range(0, 134217728)) - 67108864);
         end
      endcase
      m = 7'($urandom_range(0, 127));
      n = $countones(m);
      rc = (n == 0) ? 17'd65536 : 17'((65536 + n / 2) / n);
      case ($urandom_range(0, 9))
         0: rc = 17'd0;
         1: rc = 17'h1FFFF;
         2, 3: rc = 17'($urandom);
         default: ;
      endcase
      csr_write(CSR_COEF_B0, b0);
      csr_write(CSR_COEF_B1, b1);
      csr_write(CSR_COEF_A1, a1);
      csr_write(CSR_COEF_A2, a2);
      csr_write(CSR_BED_MASK, ($urandom & ~32'h7F) | 32'(m));
      csr_write(CSR_RECIP_BEDS, ($urandom & ~32'h1FFFF) | 32'(rc));
      csr_write(CSR_DEPTH_16BIT, ($urandom & ~32'h1) | 32'($urandom_range(0, 1)));
   endtask

   // Output side: per-sample stall draw, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each output beat against the oldest expectation; watchdog on progress
   always @(posedge clock) begin
      logic [IN_W-1:0] want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (lfe_expected.size() == 0) begin
               report_mismatch("lfe_sample with nothing pending", $signed(rsp_lfe_sample), 0);
            end else begin
               want = lfe_expected.pop_front();
               if (rsp_lfe_sample !== want)
                  report_mismatch("lfe_sample", $signed(rsp_lfe_sample), $signed(want));
            end
            stall_left = idle_on ? $urandom_range(0, 9) : 0;
            quiet_cycles = 0;
         end else if (req_valid && req_stall === 1'b0) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
               $display("tb_lfe_synth_biquad_lowpass_unit failed");
               $finish;
            end
         end
      end
   end

   initial begin
      int r;
      int k;
      int len;
      int phase;
      int sent;
      bit need_drain;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed plan
      need_drain = 1'b0;
      for (r = 0; r < PLAN_ROWS; r++) begin
         if (plan[r].kind == STEP_WRITE) begin
            if (need_drain)
               drain_results();
            need_drain = 1'b0;
            csr_write(plan[r].idx, plan[r].wdata);
         end else begin
            send_frame(plan[r].frame, plan[r].fixed, plan[r].fixed_value);
            need_drain = 1'b1;
         end
      end

      // random bursts, each under a fresh setting
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         pick_setting();
         idle_on = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         len = $urandom_range(40, 160);
         for (k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
            // long output hold-off while frames keep coming
            if (phase == 2 && k == 5)
               hold_req = 1'b1;
            send_frame(rand_frame(), 1'b0, '0);
            sent++;
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (lfe_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && lfe_expected.size() == 0)
         $display("tb_lfe_synth_biquad_lowpass_unit passed");
      else
         $display("tb_lfe_synth_biquad_lowpass_unit failed");
      $finish;
   end

endmodule
